// ----- sv/assert_macros.svh -----
// Assertion macros shared by the format list parser RTL.
// No dependencies; included by every file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfl assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SFL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfl assertion failed");

`endif

// ----- sv/sfl_pkg.sv -----
// Types, codes and constants of the stream format list parser.
// No dependencies; used by every module of the block.
package sfl_pkg;

    localparam int MAX_OPERAND_BYTES_DEF = 512;

    // Operand positions inside the response.
    localparam int POS_INDEX  = 7;
    localparam int POS_HDR0   = 8;
    localparam int POS_HDR1   = 9;
    localparam int POS_RATE   = 10;
    localparam int POS_COUNT  = 12;
    localparam int POS_PAIRS  = 13;
    localparam int MIN_LEN    = 9;

    localparam logic [7:0] HDR_BYTE0 = 8'h90;
    localparam logic [7:0] HDR_BYTE1 = 8'h40;
    localparam logic [7:0] FMT_PCM0  = 8'h00;
    localparam logic [7:0] FMT_PCM1  = 8'h06;
    localparam logic [7:0] FMT_MIDI  = 8'h0d;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_HEADER   = 3'd2,
        ST_TRUNC    = 3'd3,
        ST_FORMAT   = 3'd4,
        ST_OVERFLOW = 3'd5
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] rate_code;
        logic [7:0] pcm_channels;
        logic [7:0] midi_slots;
    } result_item_t;

endpackage

// ----- sv/stream_format_list_parser.sv -----
// Top level of the stream format list parser: input register, parse core, result register.
// Depends on sfl_pkg, sfl_parse, sfl_out_stage and assert_macros.svh.
//
//  channel   direction  handshake                   payload
//  byte      in         byte_valid / byte_stall     byte_data   (sfl_pkg::byte_item_t)
//  result    out        result_valid / result_stall result_data (sfl_pkg::result_item_t)
//  config    in         cfg_write                   cfg_data    (requested_index)
//
// One operand byte per cycle is accepted while byte_stall is low. A final byte enters
// the input register at its transfer; its result enters the result register when that
// byte moves on, and from there it can transfer on the result channel.
// The per-byte work is compares, one 8-bit add and position adds between the two registers.
// Reset (rst_n, async, active low) clears all control and parse state and the index.
// A stalled result holds the result register; a final byte waiting behind it stalls
// the byte channel, while non-final bytes keep flowing.
`include "assert_macros.svh"

module stream_format_list_parser #(
    parameter int MAX_OPERAND_BYTES = sfl_pkg::MAX_OPERAND_BYTES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [7:0]            cfg_data,
    input  logic                  byte_valid,
    output logic                  byte_stall,
    input  sfl_pkg::byte_item_t   byte_data,
    output logic                  result_valid,
    input  logic                  result_stall,
    output sfl_pkg::result_item_t result_data
);

    logic [7:0]            index_reg;
    logic                  in_vld_reg, in_vld_next;
    sfl_pkg::byte_item_t   in_item_reg;
    logic                  out_ready;
    logic                  advance;
    logic                  last_moves;
    sfl_pkg::result_item_t parse_result;
    logic                  fault_out;
    logic                  fields_zero;
    logic                  out_blocked;

    // Configuration register; to be written only while the block is idle, which it does not enforce.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            index_reg <= 8'd0;
        else if (cfg_write)
            index_reg <= cfg_data;
    end

    // A held byte moves on unless it is final and the result register is blocked.
    assign advance     = in_vld_reg && (!in_item_reg.last_byte || out_ready);
    assign last_moves  = advance && in_item_reg.last_byte;
    assign byte_stall  = in_vld_reg && !advance;
    assign in_vld_next = byte_stall ? in_vld_reg : byte_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= in_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
            in_item_reg <= byte_data;
    end

    sfl_parse #(
        .MAX_OPERAND_BYTES (MAX_OPERAND_BYTES)
    ) u_parse (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (advance),
        .item            (in_item_reg),
        .requested_index (index_reg),
        .result          (parse_result)
    );

    sfl_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load_valid   (last_moves),
        .load_data    (parse_result),
        .ready        (out_ready),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    assign fault_out   = result_valid && (result_data.status != sfl_pkg::ST_OK);
    assign fields_zero = (result_data.rate_code == 8'd0) && (result_data.pcm_channels == 8'd0)
                         && (result_data.midi_slots == 8'd0);
    assign out_blocked = in_item_reg.last_byte && result_valid && result_stall;

    // A failed response carries zero totals.
    `SFL_ASSERT_IMP(a_fault_zero, clk, rst_n, fault_out, fields_zero)
    // Every final byte that moves on produces a result in the next cycle.
    `SFL_ASSERT_NXT(a_last_gives_result, clk, rst_n, last_moves, result_valid)
    // The byte channel only stalls on a final byte waiting for the result register.
    `SFL_ASSERT_IMP(a_stall_cause, clk, rst_n, byte_stall, out_blocked)

endmodule

// ----- sv/sfl_parse.sv -----
// Per-byte parse state and result computation of the format list parser.
// Depends on sfl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sfl_parse #(
    parameter int MAX_OPERAND_BYTES = sfl_pkg::MAX_OPERAND_BYTES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  sfl_pkg::byte_item_t   item,
    input  logic [7:0]            requested_index,
    output sfl_pkg::result_item_t result
);

    localparam int PosW = $clog2(MAX_OPERAND_BYTES + 1);
    localparam int CmpW = (PosW - 1 > 8) ? PosW - 1 : 8;

    logic [PosW-1:0]  pos_reg, pos_next;
    logic [7:0]       field_total_reg, field_total_next;
    logic [7:0]       pending_reg, pending_next;
    logic [7:0]       pcm_reg, pcm_next;
    logic [7:0]       midi_reg, midi_next;
    logic [7:0]       rate_reg, rate_next;
    sfl_pkg::status_t fault_reg, fault_next;

    logic [PosW-1:0]  q;
    logic [PosW-2:0]  pair_idx;
    logic [PosW-1:0]  len;
    logic [PosW-1:0]  len_rem;
    logic             take;
    logic             in_pairs;
    logic             is_midi;
    logic             fmt_ok;
    logic [8:0]       sum9;
    sfl_pkg::status_t fault_new;
    sfl_pkg::status_t status;

    always_comb
    begin
        pcm_next         = pcm_reg;
        midi_next        = midi_reg;
        rate_next        = rate_reg;
        field_total_next = field_total_reg;
        pending_next     = pending_reg;
        fault_new        = sfl_pkg::ST_OK;

        take     = (pos_reg < PosW'(MAX_OPERAND_BYTES));
        q        = pos_reg - PosW'(sfl_pkg::POS_PAIRS);
        pair_idx = q[PosW-1:1];
        in_pairs = (pos_reg >= PosW'(sfl_pkg::POS_PAIRS))
                   && (CmpW'(pair_idx) < CmpW'(field_total_reg));
        is_midi  = (item.data_byte == sfl_pkg::FMT_MIDI);
        fmt_ok   = is_midi || (item.data_byte == sfl_pkg::FMT_PCM0)
                   || (item.data_byte == sfl_pkg::FMT_PCM1);
        sum9     = {1'b0, (is_midi ? midi_reg : pcm_reg)} + {1'b0, pending_reg};

        if (take)
        begin
            if (pos_reg == PosW'(sfl_pkg::POS_INDEX))
            begin
                if (item.data_byte != requested_index)
                    fault_new = sfl_pkg::ST_SHORT;
            end
            else if (pos_reg == PosW'(sfl_pkg::POS_HDR0))
            begin
                if (item.data_byte != sfl_pkg::HDR_BYTE0)
                    fault_new = sfl_pkg::ST_HEADER;
            end
            else if (pos_reg == PosW'(sfl_pkg::POS_HDR1))
            begin
                if (item.data_byte != sfl_pkg::HDR_BYTE1)
                    fault_new = sfl_pkg::ST_HEADER;
            end
            else if (pos_reg == PosW'(sfl_pkg::POS_RATE))
            begin
                rate_next = item.data_byte;
            end
            else if (pos_reg == PosW'(sfl_pkg::POS_COUNT))
            begin
                field_total_next = item.data_byte;
            end
            else if (in_pairs)
            begin
                if (!q[0])
                    pending_next = item.data_byte;
                else if (!fmt_ok)
                    fault_new = sfl_pkg::ST_FORMAT;
                else if (sum9[8])
                    fault_new = sfl_pkg::ST_OVERFLOW;
                else if (is_midi)
                    midi_next = sum9[7:0];
                else
                    pcm_next = sum9[7:0];
            end
        end

        // only the first fault of a response sticks
        fault_next = (fault_reg == sfl_pkg::ST_OK) ? fault_new : fault_reg;
        len        = take ? pos_reg + PosW'(1) : pos_reg;
        pos_next   = len;
        len_rem    = (len - PosW'(sfl_pkg::POS_PAIRS)) >> 1;

        if (len < PosW'(sfl_pkg::MIN_LEN) || fault_next == sfl_pkg::ST_SHORT)
            status = sfl_pkg::ST_SHORT;
        else if (len < PosW'(sfl_pkg::POS_PAIRS) || fault_next == sfl_pkg::ST_HEADER)
            status = sfl_pkg::ST_HEADER;
        else if (CmpW'(field_total_next) > CmpW'(len_rem))
            status = sfl_pkg::ST_TRUNC;
        else
            status = fault_next;

        result.status = status;
        if (status == sfl_pkg::ST_OK)
        begin
            result.rate_code    = rate_next;
            result.pcm_channels = pcm_next;
            result.midi_slots   = midi_next;
        end
        else
        begin
            result.rate_code    = 8'd0;
            result.pcm_channels = 8'd0;
            result.midi_slots   = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            field_total_reg <= '0;
            pending_reg     <= '0;
            pcm_reg         <= '0;
            midi_reg        <= '0;
            rate_reg        <= '0;
            fault_reg       <= sfl_pkg::ST_OK;
        end
        else if (step)
        begin
            if (item.last_byte)
            begin
                pos_reg         <= '0;
                field_total_reg <= '0;
                pending_reg     <= '0;
                pcm_reg         <= '0;
                midi_reg        <= '0;
                rate_reg        <= '0;
                fault_reg       <= sfl_pkg::ST_OK;
            end
            else
            begin
                pos_reg         <= pos_next;
                field_total_reg <= field_total_next;
                pending_reg     <= pending_next;
                pcm_reg         <= pcm_next;
                midi_reg        <= midi_next;
                rate_reg        <= rate_next;
                fault_reg       <= fault_next;
            end
        end
    end

    `SFL_ASSERT_IMP(a_pos_bound, clk, rst_n, 1'b1, pos_reg <= PosW'(MAX_OPERAND_BYTES))
    `SFL_ASSERT_NXT(a_clear_after_last, clk, rst_n, step && item.last_byte, (pos_reg == '0) && (fault_reg == sfl_pkg::ST_OK))

endmodule

// ----- sv/sfl_out_stage.sv -----
// Result register of the format list parser, decoupling the result stall.
// Depends on sfl_pkg.
module sfl_out_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load_valid,
    input  sfl_pkg::result_item_t load_data,
    output logic                  ready,
    output logic                  result_valid,
    input  logic                  result_stall,
    output sfl_pkg::result_item_t result_data
);

    logic                  valid_reg, valid_next;
    sfl_pkg::result_item_t data_reg;

    assign ready      = !valid_reg || !result_stall;
    assign valid_next = ready ? load_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ready && load_valid)
            data_reg <= load_data;
    end

    assign result_valid = valid_reg;
    assign result_data  = data_reg;

endmodule

// ----- sim/stream_format_list_parser_tb.sv -----
// Self-checking testbench for stream_format_list_parser: directed response table, then
// random format-list responses under random valid/stall pacing. Depends on sfl_pkg and the RTL.
module stream_format_list_parser_tb;

    localparam int MAX_BYTES   = sfl_pkg::MAX_OPERAND_BYTES_DEF;
    localparam int QUIET_LIMIT = 2000;    // cycles with no transfer before giving up
    localparam int HOLD_CYCLES = 300;     // long result hold-off for the back-pressure phase
    localparam int PHASE_BYTES = 25;      // random bytes per index setting
    localparam int NUM_PHASES  = 3;
    localparam int BRIEF_COUNT = 5;       // short responses sent against the hold-off

    typedef logic [7:0] octet_q_t [$];

    // One directed response: length sent, the fixed operands, up to four pairs
    // (channel, format, ...) packed from the top byte, and an optional typed result.
    typedef struct packed {
        logic [9:0]            len;
        logic [7:0]            idx;
        logic [15:0]           hdr;
        logic [7:0]            rate;
        logic [7:0]            nfld;
        logic [63:0]           pairs;
        logic                  typed;
        sfl_pkg::result_item_t want;
    } resp_case_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [7:0]            cfg_data = '0;
    logic                  byte_valid = 1'b0;
    logic                  byte_stall;
    sfl_pkg::byte_item_t   byte_data = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    sfl_pkg::result_item_t result_data;

    // Travels with each byte: on a final byte, use the typed result instead of the predictor's.
    logic                  typed_flag = 1'b0;
    sfl_pkg::result_item_t typed_result = '0;

    // Parse state tracked alongside the block
    logic [7:0]            want_index = '0;
    int unsigned           parse_pos = 0;
    logic [7:0]            field_count = '0;
    logic [7:0]            chan_hold = '0;
    logic [7:0]            pcm_acc = '0;
    logic [7:0]            midi_acc = '0;
    logic [7:0]            rate_seen = '0;
    sfl_pkg::status_t      fault_seen = sfl_pkg::ST_OK;

    sfl_pkg::result_item_t pending_results [$];

    int          mismatch_count = 0;
    int          results_checked = 0;
    int          bytes_sent = 0;
    int          responses_sent = 0;
    int          index_writes = 0;
    int unsigned quiet_cycles = 0;
    int          pace_mode = 0;      // 0 no idling, 1 full random, 2 mostly back to back
    bit          long_hold_req = 1'b0;
    logic [7:0]  cur_index = '0;

    resp_case_t resp_cases [20] = '{
        // len     idx     hdr       rate   nfld   pairs                    typed
        '{10'd13,  8'h00, 16'h9040, 8'h03, 8'h00, 64'h0,                   1'b1,
          '{sfl_pkg::ST_OK, 8'h03, 8'h00, 8'h00}},
        '{10'd1,   8'h00, 16'h9040, 8'h00, 8'h00, 64'h0,                   1'b1,
          '{sfl_pkg::ST_SHORT, 8'h00, 8'h00, 8'h00}},
        '{10'd8,   8'h00, 16'h9040, 8'h00, 8'h00, 64'h0,                   1'b1,
          '{sfl_pkg::ST_SHORT, 8'h00, 8'h00, 8'h00}},
        '{10'd15,  8'h05, 16'h9040, 8'h11, 8'h00, 64'h0,                   1'b1,
          '{sfl_pkg::ST_SHORT, 8'h00, 8'h00, 8'h00}},
        '{10'd13,  8'h09, 16'h0040, 8'h11, 8'h00, 64'h0,                   1'b1,
          '{sfl_pkg::ST_SHORT, 8'h00, 8'h00, 8'h00}},
        '{10'd13,  8'h00, 16'h9140, 8'h11, 8'h00, 64'h0,                   1'b1,
          '{sfl_pkg::ST_HEADER, 8'h00, 8'h00, 8'h00}},
        '{10'd13,  8'h00, 16'h9041, 8'h11, 8'h00, 64'h0,                   1'b1,
          '{sfl_pkg::ST_HEADER, 8'h00, 8'h00, 8'h00}},
        '{10'd9,   8'h00, 16'h9040, 8'h11, 8'h00, 64'h0,                   1'b1,
          '{sfl_pkg::ST_HEADER, 8'h00, 8'h00, 8'h00}},
        '{10'd12,  8'h00, 16'h9040, 8'h11, 8'h00, 64'h0,                   1'b1,
          '{sfl_pkg::ST_HEADER, 8'h00, 8'h00, 8'h00}},
        '{10'd17,  8'h00, 16'h9040, 8'h04, 8'h02, 64'h0200_010d_0000_0000, 1'b1,
          '{sfl_pkg::ST_OK, 8'h04, 8'h02, 8'h01}},
        '{10'd18,  8'h00, 16'h9040, 8'h04, 8'h03, 64'h0200_010d_0000_0000, 1'b1,
          '{sfl_pkg::ST_TRUNC, 8'h00, 8'h00, 8'h00}},
        '{10'd15,  8'h00, 16'h9040, 8'h04, 8'h01, 64'h0207_0000_0000_0000, 1'b1,
          '{sfl_pkg::ST_FORMAT, 8'h00, 8'h00, 8'h00}},
        '{10'd17,  8'h00, 16'h9040, 8'h04, 8'h02, 64'hff00_0106_0000_0000, 1'b1,
          '{sfl_pkg::ST_OVERFLOW, 8'h00, 8'h00, 8'h00}},
        // overflow in pair two is met before the bad format in pair three
        '{10'd19,  8'h00, 16'h9040, 8'h04, 8'h03, 64'hff06_0100_0107_0000, 1'b1,
          '{sfl_pkg::ST_OVERFLOW, 8'h00, 8'h00, 8'h00}},
        // bad format wins inside one pair, channels never added
        '{10'd17,  8'h00, 16'h9040, 8'h04, 8'h02, 64'hff06_05ff_0000_0000, 1'b1,
          '{sfl_pkg::ST_FORMAT, 8'h00, 8'h00, 8'h00}},
        // full totals; trailing pair with a bad format is past the count, ignored
        '{10'd21,  8'h00, 16'h9040, 8'hff, 8'h02, 64'hff0d_ff06_5507_0000, 1'b1,
          '{sfl_pkg::ST_OK, 8'hff, 8'hff, 8'hff}},
        '{10'd20,  8'h00, 16'h9040, 8'h04, 8'hff, 64'h0,                   1'b1,
          '{sfl_pkg::ST_TRUNC, 8'h00, 8'h00, 8'h00}},
        '{10'd16,  8'h00, 16'h9040, 8'h00, 8'h00, 64'h0,                   1'b1,
          '{sfl_pkg::ST_OK, 8'h00, 8'h00, 8'h00}},
        // oversized: the byte past the limit is dropped, so 250 counted pairs no longer fit
        '{10'd513, 8'h00, 16'h9040, 8'h04, 8'hfa, 64'h0,                   1'b1,
          '{sfl_pkg::ST_TRUNC, 8'h00, 8'h00, 8'h00}},
        '{10'd25,  8'h00, 16'h9040, 8'h33, 8'h04, 64'h800d_7f0d_010d_0500, 1'b0, '0}
    };

    always #2 clk = ~clk;

    stream_format_list_parser u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    function automatic int unsigned draw_wait();
        case (pace_mode)
            0:       return 0;
            1:       return $urandom_range(0, 15);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
        endcase
    endfunction

    function automatic void latch_fault(input sfl_pkg::status_t code);
        if (fault_seen == sfl_pkg::ST_OK)
            fault_seen = code;
    endfunction

    // Advance the tracked parse by one byte; on a final byte, produce the response status.
    function automatic void absorb_byte(input sfl_pkg::byte_item_t it, output bit made,
                                        output sfl_pkg::result_item_t res);
        logic [7:0]       b;
        logic [8:0]       sum;
        int unsigned      off;
        sfl_pkg::status_t st;
        b    = it.data_byte;
        made = 1'b0;
        res  = '0;
        if (parse_pos < MAX_BYTES)
        begin
            if (parse_pos == sfl_pkg::POS_INDEX)
            begin
                if (b != want_index)
                    latch_fault(sfl_pkg::ST_SHORT);
            end
            else if (parse_pos == sfl_pkg::POS_HDR0)
            begin
                if (b != sfl_pkg::HDR_BYTE0)
                    latch_fault(sfl_pkg::ST_HEADER);
            end
            else if (parse_pos == sfl_pkg::POS_HDR1)
            begin
                if (b != sfl_pkg::HDR_BYTE1)
                    latch_fault(sfl_pkg::ST_HEADER);
            end
            else if (parse_pos == sfl_pkg::POS_RATE)
                rate_seen = b;
            else if (parse_pos == sfl_pkg::POS_COUNT)
                field_count = b;
            else if (parse_pos >= sfl_pkg::POS_PAIRS)
            begin
                off = parse_pos - sfl_pkg::POS_PAIRS;
                if ((off >> 1) < field_count)
                begin
                    if (off % 2 == 0)
                        chan_hold = b;
                    else if (b != sfl_pkg::FMT_PCM0 && b != sfl_pkg::FMT_PCM1
                             && b != sfl_pkg::FMT_MIDI)
                        latch_fault(sfl_pkg::ST_FORMAT);
                    else
                    begin
                        sum = {1'b0, ((b == sfl_pkg::FMT_MIDI) ? midi_acc : pcm_acc)}
                              + {1'b0, chan_hold};
                        if (sum > 9'd255)
                            latch_fault(sfl_pkg::ST_OVERFLOW);   // pair not added
                        else if (b == sfl_pkg::FMT_MIDI)
                            midi_acc = sum[7:0];
                        else
                            pcm_acc = sum[7:0];
                    end
                end
            end
            parse_pos++;
        end
        if (it.last_byte)
        begin
            if (parse_pos < sfl_pkg::MIN_LEN || fault_seen == sfl_pkg::ST_SHORT)
                st = sfl_pkg::ST_SHORT;
            else if (parse_pos < sfl_pkg::POS_PAIRS || fault_seen == sfl_pkg::ST_HEADER)
                st = sfl_pkg::ST_HEADER;
            else if (field_count > (parse_pos - sfl_pkg::POS_PAIRS) / 2)
                st = sfl_pkg::ST_TRUNC;
            else
                st = fault_seen;
            made       = 1'b1;
            res.status = st;
            if (st == sfl_pkg::ST_OK)
            begin
                res.rate_code    = rate_seen;
                res.pcm_channels = pcm_acc;
                res.midi_slots   = midi_acc;
            end
            parse_pos   = 0;
            field_count = '0;
            chan_hold   = '0;
            pcm_acc     = '0;
            midi_acc    = '0;
            rate_seen   = '0;
            fault_seen  = sfl_pkg::ST_OK;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("MISMATCH result %0d %s: got %0h want %0h", results_checked, what, got, want);
    endtask

    task automatic check_result(input sfl_pkg::result_item_t got);
        sfl_pkg::result_item_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch("unexpected result", 32'(got), '0);
            return;
        end
        want = pending_results.pop_front();
        if (got.status != want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.rate_code != want.rate_code)
            report_mismatch("rate_code", 32'(got.rate_code), 32'(want.rate_code));
        if (got.pcm_channels != want.pcm_channels)
            report_mismatch("pcm_channels", 32'(got.pcm_channels), 32'(want.pcm_channels));
        if (got.midi_slots != want.midi_slots)
            report_mismatch("midi_slots", 32'(got.midi_slots), 32'(want.midi_slots));
        results_checked++;
    endtask

    // Sample both channels at the edge; index writes land where the block takes them.
    always @(posedge clk)
    begin : scoreboard
        sfl_pkg::result_item_t calc;
        bit                    made;
        if (rst_n)
        begin
            if (cfg_write)
                want_index = cfg_data;
            if (result_valid && !result_stall)
                check_result(result_data);
            if (byte_valid && !byte_stall)
            begin
                absorb_byte(byte_data, made, calc);
                if (made)
                    pending_results.insert(pending_results.size(),
                                           typed_flag ? typed_result : calc);
            end
        end
    end

    // Watchdog on transfers of either channel
    always @(posedge clk)
    begin
        if ((byte_valid && !byte_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : watchdog
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, pending_results.size());
        $display("Test completed with failures");
        $finish;
    end

    // Result side: a drawn stall before each transfer, or the one long hold-off on request.
    initial
    begin : result_side
        int unsigned pause;
        forever
        begin
            if (long_hold_req)
            begin
                pause = HOLD_CYCLES;
                long_hold_req = 1'b0;
            end
            else
                pause = draw_wait();
            if (pause > 0)
            begin
                result_stall <= 1'b1;
                repeat (pause) @(posedge clk);
                result_stall <= 1'b0;
            end
            do @(posedge clk); while (!result_valid);
        end
    end

    // Valid stays high across back-to-back transfers; it only drops when a gap is drawn.
    task automatic send_byte(input logic [7:0] b, input bit last, input bit is_typed,
                             input sfl_pkg::result_item_t want);
        int unsigned gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid   <= 1'b1;
        byte_data    <= '{data_byte: b, last_byte: last};
        typed_flag   <= is_typed && last;
        typed_result <= want;
        do @(posedge clk); while (byte_stall);
        bytes_sent++;
    endtask

    task automatic send_response(input octet_q_t q, input bit is_typed,
                                 input sfl_pkg::result_item_t want);
        for (int i = 0; i < q.size(); i++)
            send_byte(q[i], i == q.size() - 1, is_typed, want);
        responses_sent++;
    endtask

    // Called at the edge of the last byte transfer; drains results, then writes the index.
    task automatic set_entry_index(input logic [7:0] v);
        byte_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        cur_index = v;
        index_writes++;
    endtask

    // Mostly well-formed responses with random content; a share carries a wrong index,
    // a broken header, a cut or an out-of-range count.
    function automatic octet_q_t make_response(input bit brief);
        octet_q_t    q;
        int unsigned shape, nf, cut;
        shape = $urandom_range(0, 99);
        if (brief)
            nf = $urandom_range(0, 1);
        else if ($urandom_range(0, 31) == 0)
            nf = $urandom_range(0, 255);
        else if ($urandom_range(0, 7) == 0)
            nf = $urandom_range(6, 20);
        else
            nf = $urandom_range(0, 5);
        for (int p = 0; p < sfl_pkg::POS_PAIRS; p++)
            q.insert(q.size(), 8'($urandom));
        q[sfl_pkg::POS_INDEX] = (!brief && shape < 6) ? 8'($urandom) : cur_index;
        q[sfl_pkg::POS_HDR0]  = (!brief && shape >= 6 && shape < 10) ? 8'($urandom)
                                                                     : sfl_pkg::HDR_BYTE0;
        q[sfl_pkg::POS_HDR1]  = (!brief && shape >= 10 && shape < 14) ? 8'($urandom)
                                                                      : sfl_pkg::HDR_BYTE1;
        q[sfl_pkg::POS_COUNT] = 8'(nf);
        for (int k = 0; k < nf; k++)
        begin
            q.insert(q.size(), ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                           : 8'($urandom_range(0, 40)));
            case ($urandom_range(0, 9))
                0:       q.insert(q.size(), 8'($urandom));
                1, 2, 3: q.insert(q.size(), sfl_pkg::FMT_PCM0);
                4, 5, 6: q.insert(q.size(), sfl_pkg::FMT_PCM1);
                default: q.insert(q.size(), sfl_pkg::FMT_MIDI);
            endcase
        end
        repeat ($urandom_range(0, 3)) q.insert(q.size(), 8'($urandom));
        if (!brief && shape >= 14 && shape < 24)
            cut = $urandom_range(1, q.size());
        else if (nf > 20)
            cut = $urandom_range(sfl_pkg::POS_PAIRS, 60);
        else
            cut = q.size();
        while (q.size() > cut)
            void'(q.pop_back());
        return q;
    endfunction

    initial
    begin : stimulus
        octet_q_t   q;
        resp_case_t row;
        int         phase_end;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table under the reset index value
        pace_mode = 2;
        foreach (resp_cases[r])
        begin
            row = resp_cases[r];
            q.delete();
            for (int unsigned p = 0; p < row.len; p++)
            begin
                case (p)
                    sfl_pkg::POS_INDEX: q.insert(q.size(), row.idx);
                    sfl_pkg::POS_HDR0:  q.insert(q.size(), row.hdr[15:8]);
                    sfl_pkg::POS_HDR1:  q.insert(q.size(), row.hdr[7:0]);
                    sfl_pkg::POS_RATE:  q.insert(q.size(), row.rate);
                    sfl_pkg::POS_COUNT: q.insert(q.size(), row.nfld);
                    default:
                        if (p >= sfl_pkg::POS_PAIRS && p < sfl_pkg::POS_PAIRS + 8)
                            q.insert(q.size(),
                                     row.pairs[63 - 8 * (p - sfl_pkg::POS_PAIRS) -: 8]);
                        else
                            q.insert(q.size(), 8'($urandom));
                endcase
            end
            send_response(q, row.typed, row.want);
        end

        // Random phases, each under its own index and pacing
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            set_entry_index((ph == 0) ? 8'hff : (ph == 1) ? 8'h00 : 8'($urandom));
            pace_mode = ph % 3;
            phase_end = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end)
                send_response(make_response(1'b0), 1'b0, '0);

            // Back-pressure: result side holds off while short responses keep coming
            if (ph == 2)
            begin
                set_entry_index(8'($urandom));
                pace_mode = 0;
                long_hold_req = 1'b1;
                repeat (BRIEF_COUNT)
                    send_response(make_response(1'b1), 1'b0, '0);
            end
        end

        byte_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Parsed %0d responses (%0d bytes) under %0d entry index writes; %0d checked.",
                 responses_sent, bytes_sent, index_writes, results_checked);
        $display("Covered every status code, an oversized response and a %0d-cycle hold-off.",
                 HOLD_CYCLES);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/sfl_pkg.sv
sv/sfl_parse.sv
sv/sfl_out_stage.sv
sv/stream_format_list_parser.sv
sim/stream_format_list_parser_tb.sv
